@@ rtl/core/gkc_pkg.sv @@
package gkc_pkg;

  // Largest kernel side that is accepted as valid.
  localparam int unsigned MAX_SIDE = 15;

  // Shared divider sizing: the widest numerator is a Q8.24 ratio with rounding,
  // the widest denominator is a full axis sum of 1-D weights.
  localparam int unsigned DIV_NW = 57;
  localparam int unsigned DIV_DW = 36;
  localparam int unsigned DIV_CW = 6;

  // Configuration register indexes.
  localparam logic [7:0] REG_WIDTH  = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;
  localparam logic [7:0] REG_SIGMA  = 8'd2;
  localparam logic [7:0] REG_NORM   = 8'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EVEN    = 2'd1;
  localparam logic [1:0] ST_SIGMA   = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] nbits;
  } div_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SIG2,
    S_SIG2_W,
    S_D_START,
    S_D_WAIT,
    S_T_MUL,
    S_T_START,
    S_T_WAIT,
    S_CLAMP,
    S_SQ_MUL,
    S_SQ_RND,
    S_ACCUM,
    S_F_MUL,
    S_F_RND,
    S_RX_START,
    S_RX_WAIT,
    S_RY_START,
    S_RY_WAIT,
    S_N_MUL,
    S_N_RND,
    S_OUT
  } state_t;

endpackage

@@ rtl/core/gkc_div.sv @@
// Restoring divider, one quotient bit a cycle. Only the lowest nbits of the
// numerator are walked, and done rises as the last quotient bit is shifted in.
module gkc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  gkc_pkg::div_ctl_t             ctl,
  input  logic [gkc_pkg::DIV_NW-1:0]    num,
  input  logic [gkc_pkg::DIV_DW-1:0]    den,
  output logic [gkc_pkg::DIV_NW-1:0]    quo,
  output logic                          done
);

  logic [gkc_pkg::DIV_NW-1:0] nsh;
  logic [gkc_pkg::DIV_DW-1:0] rem;
  logic [gkc_pkg::DIV_DW-1:0] den_r;
  logic [gkc_pkg::DIV_CW-1:0] cnt;
  logic                       busy;
  logic [gkc_pkg::DIV_DW:0]   trial;
  logic [gkc_pkg::DIV_DW:0]   diff;
  logic                       ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem, nsh[gkc_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == gkc_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nsh   <= num << (gkc_pkg::DIV_CW'(gkc_pkg::DIV_NW) - ctl.nbits);
      rem   <= '0;
      quo   <= '0;
      den_r <= den;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= ge ? diff[gkc_pkg::DIV_DW-1:0] : trial[gkc_pkg::DIV_DW-1:0];
      quo <= {quo[gkc_pkg::DIV_NW-2:0], ge};
    end
  end

endmodule

@@ rtl/core/gaussian_kernel_coefficient.sv @@
// Gaussian kernel coefficient generator.
// The slave channel takes one word per request: s_tdata holds the kernel row
// and column. The master channel returns one word per request: m_tdata holds
// the coefficient in unsigned Q0.16 and m_tuser the status (0 ok, 1 even or
// oversized side, 2 zero sigma, 3 position outside the kernel; the
// coefficient is zero whenever the status is not ok).
// The cfg channel writes kernel width, height, sigma (Q8.8) and the normalize
// flag by index; it is always ready and must only be used while idle.
// One request is worked at a time: s_tready is low from acceptance until the
// result has been taken. For every offset from 0 to the larger half side, the
// shared divider and multiplier build a 1-D weight: one 37-step division for
// the exponent argument, twelve series terms of a multiply and a 33-step
// division each, then four squarings. With normalize set two 57-step divisions
// follow. A request with an error status can be taken in the cycle after
// acceptance. The result waits in its output register while m_tready is low.
// Reset restores width 3, height 3, sigma 1.0 and normalize on, and empties
// the block.
module gaussian_kernel_coefficient (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] row, [7:4] col
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] coefficient
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned SW = gkc_pkg::DIV_DW;

  gkc_pkg::state_t state, state_next;

  logic [3:0]  kernel_width;
  logic [3:0]  kernel_height;
  logic [15:0] sigma_q8_8;
  logic        normalize;

  logic [3:0]  row_in, col_in;
  logic [3:0]  cx4, cy4, dx4, dy4;
  logic [1:0]  status_in;

  logic [2:0]  d, dmax, dx, dy;
  logic [3:0]  k;
  logic [1:0]  sq_cnt;
  logic [31:0] s2;
  logic [32:0] term;
  logic [20:0] t;
  logic signed [34:0] acc;
  logic [31:0] v, gx, gy;
  logic [SW-1:0] sx, sy;
  logic [24:0] rx, ry;
  logic [15:0] coefficient;
  logic [1:0]  status;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod;
  logic [64:0] rnd32;
  logic [32:0] rnd16;
  logic [5:0]  d2;
  logic [SW-1:0] g_add;

  gkc_pkg::div_ctl_t          div_ctl;
  logic [gkc_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [gkc_pkg::DIV_DW-1:0] div_den;
  logic                       div_done;

  gkc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_width  <= 4'd3;
      kernel_height <= 4'd3;
      sigma_q8_8    <= 16'd256;
      normalize     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gkc_pkg::REG_WIDTH:  kernel_width  <= cfg_data[3:0];
        gkc_pkg::REG_HEIGHT: kernel_height <= cfg_data[3:0];
        gkc_pkg::REG_SIGMA:  sigma_q8_8    <= cfg_data;
        gkc_pkg::REG_NORM:   normalize     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request decode: centres, offset magnitudes and the early status.
  assign row_in = s_tdata[3:0];
  assign col_in = s_tdata[7:4];
  assign cx4    = {1'b0, kernel_width[3:1]};
  assign cy4    = {1'b0, kernel_height[3:1]};
  assign dx4    = (col_in >= cx4) ? col_in - cx4 : cx4 - col_in;
  assign dy4    = (row_in >= cy4) ? row_in - cy4 : cy4 - row_in;

  always_comb begin
    if (!kernel_width[0] || !kernel_height[0] ||
        32'(kernel_width) > gkc_pkg::MAX_SIDE ||
        32'(kernel_height) > gkc_pkg::MAX_SIDE) begin
      status_in = gkc_pkg::ST_EVEN;
    end else if (sigma_q8_8 == 16'd0) begin
      status_in = gkc_pkg::ST_SIGMA;
    end else if (row_in >= kernel_height || col_in >= kernel_width) begin
      status_in = gkc_pkg::ST_OUTSIDE;
    end else begin
      status_in = gkc_pkg::ST_OK;
    end
  end

  // Shared multiplier, product registered every cycle.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Rounding of a product to its upper half, and of that to 16 bits.
  assign rnd32 = {1'b0, prod[63:0]} + 65'(33'h080000000);
  assign rnd16 = {1'b0, rnd32[63:32]} + 33'h000008000;
  assign d2    = 6'(d) * 6'(d);
  assign g_add = (d == 3'd0) ? SW'(v) : SW'({v, 1'b0});

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gkc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gkc_pkg::S_IDLE:
        if (s_tvalid) begin
          state_next = (status_in == gkc_pkg::ST_OK) ? gkc_pkg::S_SIG2 : gkc_pkg::S_OUT;
        end
      gkc_pkg::S_SIG2:    state_next = gkc_pkg::S_SIG2_W;
      gkc_pkg::S_SIG2_W:  state_next = gkc_pkg::S_D_START;
      gkc_pkg::S_D_START: state_next = gkc_pkg::S_D_WAIT;
      gkc_pkg::S_D_WAIT:  if (div_done) state_next = gkc_pkg::S_T_MUL;
      gkc_pkg::S_T_MUL:   state_next = gkc_pkg::S_T_START;
      gkc_pkg::S_T_START: state_next = gkc_pkg::S_T_WAIT;
      gkc_pkg::S_T_WAIT:
        if (div_done) begin
          state_next = (k == 4'd12) ? gkc_pkg::S_CLAMP : gkc_pkg::S_T_MUL;
        end
      gkc_pkg::S_CLAMP:   state_next = gkc_pkg::S_SQ_MUL;
      gkc_pkg::S_SQ_MUL:  state_next = gkc_pkg::S_SQ_RND;
      gkc_pkg::S_SQ_RND:
        state_next = (sq_cnt == 2'd3) ? gkc_pkg::S_ACCUM : gkc_pkg::S_SQ_MUL;
      gkc_pkg::S_ACCUM:
        if (d != dmax) begin
          state_next = gkc_pkg::S_D_START;
        end else begin
          state_next = normalize ? gkc_pkg::S_RX_START : gkc_pkg::S_F_MUL;
        end
      gkc_pkg::S_F_MUL:   state_next = gkc_pkg::S_F_RND;
      gkc_pkg::S_F_RND:   state_next = gkc_pkg::S_OUT;
      gkc_pkg::S_RX_START:
        state_next = (sx == '0 || sy == '0) ? gkc_pkg::S_OUT : gkc_pkg::S_RX_WAIT;
      gkc_pkg::S_RX_WAIT: if (div_done) state_next = gkc_pkg::S_RY_START;
      gkc_pkg::S_RY_START: state_next = gkc_pkg::S_RY_WAIT;
      gkc_pkg::S_RY_WAIT: if (div_done) state_next = gkc_pkg::S_N_MUL;
      gkc_pkg::S_N_MUL:   state_next = gkc_pkg::S_N_RND;
      gkc_pkg::S_N_RND:   state_next = gkc_pkg::S_OUT;
      gkc_pkg::S_OUT:     if (m_tready) state_next = gkc_pkg::S_IDLE;
      default:            state_next = gkc_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes, multiplier operands, divider requests.
  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_ctl.start = 1'b0;
    div_ctl.nbits = '0;
    div_num       = '0;
    div_den       = '0;
    unique case (state)
      gkc_pkg::S_IDLE: s_tready = 1'b1;
      gkc_pkg::S_OUT:  m_tvalid = 1'b1;
      gkc_pkg::S_SIG2: begin
        mul_a = 33'(sigma_q8_8);
        mul_b = 33'(sigma_q8_8);
      end
      gkc_pkg::S_D_START: begin
        // Exponent argument: d*d*2^31 / sigma^2.
        div_ctl.start = 1'b1;
        div_ctl.nbits = gkc_pkg::DIV_CW'(37);
        div_num       = gkc_pkg::DIV_NW'({d2, 31'd0});
        div_den       = gkc_pkg::DIV_DW'(s2);
      end
      gkc_pkg::S_T_MUL: begin
        mul_a = term;
        mul_b = 33'(t);
      end
      gkc_pkg::S_T_START: begin
        div_ctl.start = 1'b1;
        div_ctl.nbits = gkc_pkg::DIV_CW'(33);
        div_num       = gkc_pkg::DIV_NW'(prod[52:20]);
        div_den       = gkc_pkg::DIV_DW'(k);
      end
      gkc_pkg::S_SQ_MUL: begin
        mul_a = 33'(v);
        mul_b = 33'(v);
      end
      gkc_pkg::S_F_MUL: begin
        mul_a = 33'(gx);
        mul_b = 33'(gy);
      end
      gkc_pkg::S_RX_START: begin
        div_ctl.start = (sx != '0) && (sy != '0);
        div_ctl.nbits = gkc_pkg::DIV_CW'(gkc_pkg::DIV_NW);
        div_num       = gkc_pkg::DIV_NW'({gx, 24'd0}) + gkc_pkg::DIV_NW'(sx[SW-1:1]);
        div_den       = sx;
      end
      gkc_pkg::S_RY_START: begin
        div_ctl.start = 1'b1;
        div_ctl.nbits = gkc_pkg::DIV_CW'(gkc_pkg::DIV_NW);
        div_num       = gkc_pkg::DIV_NW'({gy, 24'd0}) + gkc_pkg::DIV_NW'(sy[SW-1:1]);
        div_den       = sy;
      end
      gkc_pkg::S_N_MUL: begin
        mul_a = 33'(rx);
        mul_b = 33'(ry);
      end
      default: ;
    endcase
  end

  // Datapath registers stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      gkc_pkg::S_IDLE: begin
        status      <= status_in;
        coefficient <= 16'd0;
        dx          <= dx4[2:0];
        dy          <= dy4[2:0];
        dmax        <= (cx4 > cy4) ? cx4[2:0] : cy4[2:0];
        d           <= 3'd0;
        sx          <= '0;
        sy          <= '0;
      end
      gkc_pkg::S_SIG2_W: s2 <= prod[31:0];
      gkc_pkg::S_D_WAIT: begin
        // Cap the argument at 16.0 and open the series at 1.0.
        t    <= (div_quo > gkc_pkg::DIV_NW'(21'h100000)) ? 21'h100000 : div_quo[20:0];
        term <= 33'h100000000;
        acc  <= 35'sh100000000;
        k    <= 4'd1;
      end
      gkc_pkg::S_T_WAIT:
        if (div_done) begin
          term <= div_quo[32:0];
          if (k[0]) begin
            acc <= acc - $signed({2'b00, div_quo[32:0]});
          end else begin
            acc <= acc + $signed({2'b00, div_quo[32:0]});
          end
          k <= k + 4'd1;
        end
      gkc_pkg::S_CLAMP: begin
        if (acc[34]) begin
          v <= 32'd0;
        end else if (acc[33:32] != 2'd0) begin
          v <= 32'hFFFFFFFF;
        end else begin
          v <= acc[31:0];
        end
        sq_cnt <= 2'd0;
      end
      gkc_pkg::S_SQ_RND: begin
        v      <= rnd32[63:32];
        sq_cnt <= sq_cnt + 2'd1;
      end
      gkc_pkg::S_ACCUM: begin
        // Each nonzero offset stands twice in a side, once on either half.
        if (d <= cx4[2:0]) sx <= sx + g_add;
        if (d <= cy4[2:0]) sy <= sy + g_add;
        if (d == dx) gx <= v;
        if (d == dy) gy <= v;
        d <= d + 3'd1;
      end
      gkc_pkg::S_F_RND:
        coefficient <= (rnd16[32:16] > 17'h0FFFF) ? 16'hFFFF : rnd16[31:16];
      gkc_pkg::S_RX_START:
        if (sx == '0 || sy == '0) coefficient <= 16'd0;
      gkc_pkg::S_RX_WAIT: if (div_done) rx <= div_quo[24:0];
      gkc_pkg::S_RY_WAIT: if (div_done) ry <= div_quo[24:0];
      gkc_pkg::S_N_RND:
        coefficient <= (rnd32[64:32] > 33'h00000FFFF) ? 16'hFFFF : rnd32[47:32];
      default: ;
    endcase
  end

  assign m_tdata = coefficient;
  assign m_tuser = status;

endmodule
